[hw/rtl/hwps_pkg.sv]
`timescale 1ns / 1ps

package hwps_pkg;

  localparam int POINTS    = 320;
  localparam int HARMONICS = 5;
  localparam int HEIGHT    = 240;
  localparam int SINE_BITS = 10;

  localparam int NUM_REGS  = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;
  localparam int HIDX_W    = $clog2(NUM_REGS);

  localparam int Y_W   = 8;
  localparam int COL_W = 9;

  localparam int CNT_W   = $clog2(POINTS);
  localparam int N_W     = CNT_W + 16;
  localparam int PROD_W  = N_W + 32;
  localparam int QEST_W  = 17;
  localparam int AMP_W   = 16;
  localparam int SIN_W   = 16;
  localparam int ASUM_W  = AMP_W + $clog2(HARMONICS);
  localparam int ACC_W   = ASUM_W + SIN_W;
  localparam int D_W     = ASUM_W + 15;
  localparam int POS_W   = D_W + 1;
  localparam int QW      = $clog2(HEIGHT + 1);
  localparam int NUM_W   = D_W + QW + 1;
  localparam int DCNT_W  = (QW > 1) ? $clog2(QW) : 1;
  localparam int QSIZE   = 1 << (SINE_BITS - 2);
  localparam int QA_W    = SINE_BITS - 1;

  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / POINTS);

  typedef logic [14:0] qsin_t [0:QSIZE];

  function automatic qsin_t build_qsin();
    qsin_t       tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] r;
    for (int q = 0; q <= QSIZE; q++) begin
      x  = (64'(q) * 64'd1686629713) >> (SINE_BITS - 2);
      x2 = (x * x) >> 30;
      t  = 64'd1 << 30;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd72;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd42;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd20;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      r  = (s + (64'd1 << 14)) >> 15;
      tab[q] = (r > 64'd32767) ? 15'h7fff : r[14:0];
    end
    return tab;
  endfunction

  localparam qsin_t QSIN = build_qsin();

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_FIX,
    ST_ROM,
    ST_MAC,
    ST_SUMD,
    ST_POS,
    ST_PREP,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic              start;
    logic              mul1;
    logic              mul2;
    logic              fix;
    logic              rom;
    logic              mac;
    logic              sumd;
    logic              pos;
    logic              prep;
    logic              div;
    logic              load_out;
    logic [HIDX_W-1:0] harm;
  } cmd_t;

  typedef struct packed {
    logic zero;
  } sts_t;

endpackage

[hw/rtl/hwps_dp.sv]
`timescale 1ns / 1ps

module hwps_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      restart_i,
  input  logic                      cfg_we_i,
  input  logic [hwps_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [hwps_pkg::CFG_W-1:0]     cfg_data_i,
  input  hwps_pkg::cmd_t            cmd_i,
  output hwps_pkg::sts_t            sts_o,
  output logic [hwps_pkg::Y_W-1:0]  y_pixel_o,
  output logic [hwps_pkg::COL_W-1:0] column_o,
  output logic                      end_of_sweep_o,
  output logic                      zero_sum_o
);
  import hwps_pkg::*;

  logic [CFG_W-1:0]  harm_q [NUM_REGS];
  logic [CNT_W-1:0]  cnt_q;

  logic [CNT_W-1:0]  col_q;
  logic [CNT_W-1:0]  rm_q;
  logic [N_W-1:0]    n_q;
  logic [PROD_W-1:0] prod_q;
  logic [QEST_W-1:0] qest_q;
  logic [N_W-1:0]    qp_q;
  logic [SINE_BITS-1:0] idx_q;
  logic signed [SIN_W-1:0] sine_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [ASUM_W-1:0] asum_q;
  logic [D_W-1:0]    d_q;
  logic [POS_W-1:0]  pos_q;
  logic [NUM_W-1:0]  num_q;
  logic [NUM_W-1:0]  den_q;
  logic [QW-1:0]     quo_q;
  logic [Y_W-1:0]    y_q;
  logic [COL_W-1:0]  colo_q;
  logic              eos_q;
  logic              zero_q;

  logic [CNT_W-1:0]  col_new;
  logic [CNT_W-1:0]  cnt_d;
  logic [AMP_W-1:0]  amp;
  logic [15:0]       phase;
  logic [N_W-1:0]    n_new;
  logic [N_W-1:0]    qest_full;
  logic [N_W-1:0]    rem;
  logic [QEST_W-1:0] base;
  logic [15:0]       angle;
  logic [1:0]        quad;
  logic [QA_W-1:0]   qaddr;
  logic [14:0]       mag;
  logic signed [AMP_W:0] amp_s;
  logic signed [AMP_W+SIN_W:0] mprod;
  logic [CNT_W:0]    rm_sum;
  logic signed [D_W+1:0] pos_s;
  logic              ge;
  logic              zero;
  logic [Y_W-1:0]    y_new;

  assign col_new = restart_i ? '0 : cnt_q;
  assign cnt_d   = (col_new >= CNT_W'(POINTS - 1)) ? '0 : col_new + CNT_W'(1);

  assign amp   = harm_q[cmd_i.harm][31:16];
  assign phase = harm_q[cmd_i.harm][15:0];

  assign n_new     = {rm_q, 16'h0000} + N_W'(POINTS / 2);
  assign qest_full = prod_q[PROD_W-1:32];
  assign rem       = n_q - qp_q;
  assign base      = qest_q + QEST_W'(rem >= N_W'(POINTS));
  assign angle     = base[15:0] + phase;

  assign quad  = idx_q[SINE_BITS-1 -: 2];
  assign qaddr = quad[0] ? QA_W'(QSIZE) - QA_W'(idx_q[SINE_BITS-3:0])
                         : QA_W'(idx_q[SINE_BITS-3:0]);
  assign mag   = QSIN[qaddr];

  assign amp_s  = signed'({1'b0, amp});
  assign mprod  = amp_s * sine_q;
  assign rm_sum = (CNT_W+1)'(rm_q) + (CNT_W+1)'(col_q);

  assign pos_s = (D_W+2)'(acc_q) + signed'({2'b00, d_q});
  assign ge    = num_q >= den_q;

  assign zero  = (asum_q == '0);
  assign y_new = zero ? Y_W'(HEIGHT / 2)
               : (quo_q > QW'(HEIGHT)) ? Y_W'(HEIGHT) : Y_W'(quo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        harm_q[i] <= '0;
      end
      cnt_q <= '0;
    end else begin
      if (cfg_we_i && (cfg_idx_i < CFG_IDX_W'(NUM_REGS))) begin
        harm_q[cfg_idx_i] <= cfg_data_i;
      end
      if (cmd_i.start) begin
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      col_q  <= col_new;
      rm_q   <= col_new;
      acc_q  <= '0;
      asum_q <= '0;
    end
    if (cmd_i.mul1) begin
      n_q    <= n_new;
      prod_q <= PROD_W'(n_new) * PROD_W'(RECIP);
    end
    if (cmd_i.mul2) begin
      qest_q <= QEST_W'(qest_full);
      qp_q   <= qest_full * N_W'(POINTS);
    end
    if (cmd_i.fix) begin
      idx_q <= angle[15 -: SINE_BITS];
    end
    if (cmd_i.rom) begin
      sine_q <= quad[1] ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
    end
    if (cmd_i.mac) begin
      acc_q  <= acc_q + ACC_W'(mprod);
      asum_q <= asum_q + ASUM_W'(amp);
      rm_q   <= (rm_sum >= (CNT_W+1)'(POINTS)) ? CNT_W'(rm_sum - (CNT_W+1)'(POINTS))
                                               : CNT_W'(rm_sum);
    end
    if (cmd_i.sumd) begin
      d_q <= (D_W'(asum_q) << 15) - D_W'(asum_q);
    end
    if (cmd_i.pos) begin
      pos_q <= pos_s[D_W+1] ? '0 : pos_s[D_W:0];
    end
    if (cmd_i.prep) begin
      num_q <= NUM_W'(pos_q) * NUM_W'(HEIGHT) + NUM_W'(d_q);
      den_q <= NUM_W'({d_q, 1'b0}) << (QW - 1);
      quo_q <= '0;
    end
    if (cmd_i.div) begin
      if (ge) begin
        num_q <= num_q - den_q;
      end
      den_q <= den_q >> 1;
      quo_q <= {quo_q[QW-2:0], ge};
    end
    if (cmd_i.load_out) begin
      y_q    <= y_new;
      colo_q <= COL_W'(col_q);
      eos_q  <= (col_q == CNT_W'(POINTS - 1));
      zero_q <= zero;
    end
  end

  assign sts_o.zero     = zero;
  assign y_pixel_o      = y_q;
  assign column_o       = colo_q;
  assign end_of_sweep_o = eos_q;
  assign zero_sum_o     = zero_q;

endmodule

[hw/rtl/hwps_ctrl.sv]
`timescale 1ns / 1ps

module hwps_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  hwps_pkg::sts_t sts_i,
  output hwps_pkg::cmd_t cmd_o
);
  import hwps_pkg::*;

  state_e             state_q;
  state_e             state_d;
  logic [HIDX_W-1:0]  k_q;
  logic [DCNT_W-1:0]  dcnt_q;
  logic               out_valid_q;
  logic               out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_MUL1;
        end
      end
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_FIX;
      ST_FIX:  state_d = ST_ROM;
      ST_ROM:  state_d = ST_MAC;
      ST_MAC: begin
        state_d = (k_q == HIDX_W'(HARMONICS - 1)) ? ST_SUMD : ST_MUL1;
      end
      ST_SUMD: state_d = sts_i.zero ? ST_OUT : ST_POS;
      ST_POS:  state_d = ST_PREP;
      ST_PREP: state_d = ST_DIV;
      ST_DIV: begin
        if (dcnt_q == DCNT_W'(QW - 1)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.harm     = k_q;
    cmd_o.start    = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.mul1     = (state_q == ST_MUL1);
    cmd_o.mul2     = (state_q == ST_MUL2);
    cmd_o.fix      = (state_q == ST_FIX);
    cmd_o.rom      = (state_q == ST_ROM);
    cmd_o.mac      = (state_q == ST_MAC);
    cmd_o.sumd     = (state_q == ST_SUMD);
    cmd_o.pos      = (state_q == ST_POS);
    cmd_o.prep     = (state_q == ST_PREP);
    cmd_o.div      = (state_q == ST_DIV);
    cmd_o.load_out = (state_q == ST_OUT) && out_free;
    in_stall_o     = (state_q != ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.start) begin
        k_q <= '0;
      end else if (cmd_o.mac && (k_q != HIDX_W'(HARMONICS - 1))) begin
        k_q <= k_q + HIDX_W'(1);
      end
      if (cmd_o.prep) begin
        dcnt_q <= '0;
      end else if (cmd_o.div) begin
        dcnt_q <= dcnt_q + DCNT_W'(1);
      end
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  a_start_enters_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_MUL1 && k_q == '0))
    else $error("Accepted transaction did not start the harmonic loop.");

  a_harm_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= HIDX_W'(HARMONICS - 1))
    else $error("Harmonic index out of range.");

  a_no_div_on_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> !sts_i.zero)
    else $error("Divider running with a zero amplitude sum.");

  a_valid_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT))
    else $error("Output valid raised outside the output state.");

endmodule

[hw/rtl/harmonic_waveform_point_synth_unit.sv]
`timescale 1ns / 1ps

// Each input transaction produces one waveform point for the next column of the
// period: the weighted sum of five harmonics read from a quarter-wave sine table,
// normalized by the amplitude sum and scaled to 0..HEIGHT, with restart_i clearing
// the column counter first. Each transaction, accepted only while the unit is idle,
// runs each of the five harmonics in turn through the shared angle, table and
// multiply-accumulate path, then the scaling steps and the bit-serial restoring
// divider; a zero amplitude sum skips the later scaling steps and the divider. A
// finished point waits in the output register while the next is already accepted.
module harmonic_waveform_point_synth_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           restart_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [hwps_pkg::Y_W-1:0]       y_pixel_o,
  output logic [hwps_pkg::COL_W-1:0]     column_o,
  output logic                           end_of_sweep_o,
  output logic                           zero_sum_o,
  input  logic                           cfg_we_i,
  input  logic [hwps_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [hwps_pkg::CFG_W-1:0]     cfg_data_i
);
  import hwps_pkg::*;

  cmd_t cmd;
  sts_t sts;

  hwps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  hwps_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .restart_i      (restart_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .y_pixel_o      (y_pixel_o),
    .column_o       (column_o),
    .end_of_sweep_o (end_of_sweep_o),
    .zero_sum_o     (zero_sum_o)
  );

endmodule
